>>> hw/rtl/sssl_pkg.sv
// Shared constants, types and command codes for the sparse matrix lookup.
`timescale 1ns / 1ps

package sssl_pkg;

    localparam int SIZE      = 32;
    localparam int NEIGHBORS = 8;

    localparam int ROW_W  = 5;
    localparam int VAL_W  = 32;
    localparam int N_W    = $clog2(SIZE) + 1;
    localparam int SLOT_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int FILL_W = $clog2(NEIGHBORS + 1);
    localparam int ADDR_W = ROW_W + SLOT_W;
    localparam int DEPTH  = SIZE * (1 << SLOT_W);

    localparam logic [2:0] CMD_LOAD      = 3'd0;
    localparam logic [2:0] CMD_GET_VALUE = 3'd1;
    localparam logic [2:0] CMD_GET_ROW   = 3'd2;
    localparam logic [2:0] CMD_GET_COL   = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [ROW_W-1:0]  idx_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [N_W-1:0]    size_t;

    typedef struct packed {
        idx_t col;
        val_t val;
    } slot_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        slot_t             wr_slot;
        logic              fill_inc;
        idx_t              fill_row;
        logic              clear;
    } store_req_t;

    typedef struct packed {
        val_t       value;
        idx_t       position;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_CMP,
        SQ_EMIT
    } seq_state_t;

endpackage

>>> hw/rtl/sssl_slot_store.sv
// Slot memory (column and value per slot) and the per-row fill counters.
`timescale 1ns / 1ps

module sssl_slot_store (
    input  logic                clk,
    input  logic                rst_n,
    input  sssl_pkg::store_req_t req,
    output sssl_pkg::slot_t     rd_slot,
    output sssl_pkg::fill_t     fill
);
    import sssl_pkg::*;

    slot_t slot_mem [0:DEPTH-1];
    slot_t rd_slot_reg;
    fill_t fill_reg [0:SIZE-1];

    // Synchronous memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem[req.wr_addr] <= req.wr_slot;
        end
        if (req.rd_en)
        begin
            rd_slot_reg <= slot_mem[req.rd_addr];
        end
    end

    // Fill counters are cleared by reset and by the clear command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIZE; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (req.clear)
        begin
            for (int i = 0; i < SIZE; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (req.fill_inc)
        begin
            fill_reg[req.fill_row] <= fill_reg[req.fill_row] + fill_t'(1);
        end
    end

    assign rd_slot = rd_slot_reg;
    assign fill    = fill_reg[req.fill_row];

endmodule

>>> hw/rtl/sssl_seq.sv
// Command sequencer: slot searches, load updates and result generation.
`timescale 1ns / 1ps

module sssl_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           in_cmd,
    input  sssl_pkg::idx_t       in_row,
    input  sssl_pkg::idx_t       in_col,
    input  sssl_pkg::val_t       in_value,
    input  sssl_pkg::size_t      n,
    input  logic                 out_free,
    output logic                 res_valid,
    output sssl_pkg::result_t    res,
    output sssl_pkg::store_req_t req,
    input  sssl_pkg::slot_t      rd_slot,
    input  sssl_pkg::fill_t      fill
);
    import sssl_pkg::*;

    seq_state_t state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    idx_t       row_reg, row_next;
    idx_t       col_reg, col_next;
    val_t       val_reg, val_next;
    size_t      idx_reg, idx_next;
    logic       phase_reg, phase_next;
    fill_t      slot_reg, slot_next;
    logic       more_reg, more_next;
    result_t    res_reg, res_next;

    idx_t pr, pc, sr, tc;
    logic can_fall, last_pos;
    logic fin, fin_hit;
    val_t fin_val;
    logic row_oor, col_oor, oor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            more_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            more_reg  <= more_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

    // The current lookup: primary (pr, pc), and the mirrored entry as fallback for value and column queries.
    always_comb
    begin
        pr       = (cmd_reg == CMD_GET_COL) ? idx_reg[ROW_W-1:0] : row_reg;
        pc       = (cmd_reg == CMD_GET_ROW) ? idx_reg[ROW_W-1:0] : col_reg;
        sr       = phase_reg ? pc : pr;
        tc       = phase_reg ? pr : pc;
        can_fall = (cmd_reg == CMD_GET_VALUE) || (cmd_reg == CMD_GET_COL);
        last_pos = ((idx_reg + size_t'(1)) == n);
        row_oor  = ({1'b0, in_row} >= n);
        col_oor  = ({1'b0, in_col} >= n);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        more_next  = more_reg;
        res_next   = res_reg;
        fin        = 1'b0;
        fin_hit    = 1'b0;
        fin_val    = '0;
        oor        = 1'b0;

        req          = '0;
        req.fill_row = sr;
        req.rd_addr  = {sr, slot_reg[SLOT_W-1:0]};

        in_ready  = (state_reg == SQ_IDLE);
        res_valid = (state_reg == SQ_EMIT);

        case (state_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_cmd;
                    row_next   = in_row;
                    col_next   = in_col;
                    val_next   = in_value;
                    idx_next   = '0;
                    phase_next = 1'b0;
                    slot_next  = '0;
                    more_next  = 1'b0;
                    res_next   = '{value: '0, position: '0, status: ST_OK, last: 1'b1};
                    case (in_cmd)
                        CMD_LOAD:      oor = row_oor || col_oor;
                        CMD_GET_VALUE: oor = row_oor || col_oor;
                        CMD_GET_ROW:   oor = row_oor;
                        CMD_GET_COL:   oor = col_oor;
                        default:       oor = 1'b0;
                    endcase
                    if (in_cmd == CMD_CLEAR)
                    begin
                        req.clear  = 1'b1;
                        state_next = SQ_EMIT;
                    end
                    else if (in_cmd > CMD_CLEAR)
                    begin
                        state_next = SQ_EMIT;
                    end
                    else if (oor)
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = SQ_EMIT;
                    end
                    else
                    begin
                        state_next = SQ_READ;
                    end
                end
            end

            SQ_READ:
            begin
                if (slot_reg < fill)
                begin
                    req.rd_en  = 1'b1;
                    state_next = SQ_CMP;
                end
                else if (!phase_reg && can_fall)
                begin
                    phase_next = 1'b1;
                    slot_next  = '0;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            SQ_CMP:
            begin
                if (rd_slot.col == tc)
                begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                    fin_val = rd_slot.val;
                end
                else
                begin
                    slot_next  = slot_reg + fill_t'(1);
                    state_next = SQ_READ;
                end
            end

            SQ_EMIT:
            begin
                if (out_free)
                begin
                    if (more_reg)
                    begin
                        idx_next   = idx_reg + size_t'(1);
                        phase_next = 1'b0;
                        slot_next  = '0;
                        state_next = SQ_READ;
                    end
                    else
                    begin
                        state_next = SQ_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase

        // A lookup has ended: update the slot store or form the result.
        if (fin)
        begin
            state_next = SQ_EMIT;
            res_next   = '{value: '0, position: '0, status: ST_OK, last: 1'b1};
            more_next  = 1'b0;
            case (cmd_reg)
                CMD_LOAD:
                begin
                    req.wr_slot = '{col: col_reg, val: val_reg};
                    if (fin_hit)
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = {row_reg, slot_reg[SLOT_W-1:0]};
                    end
                    else if (fill >= fill_t'(NEIGHBORS))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        req.wr_en    = 1'b1;
                        req.wr_addr  = {row_reg, fill[SLOT_W-1:0]};
                        req.fill_inc = 1'b1;
                    end
                end
                CMD_GET_VALUE:
                begin
                    res_next.value = fin_val;
                end
                default:
                begin
                    res_next.value    = fin_val;
                    res_next.position = idx_reg[ROW_W-1:0];
                    res_next.last     = last_pos;
                    more_next         = !last_pos;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/sparse_symmetric_matrix_lookup.sv
// Top level of the sparse symmetric similarity matrix lookup.
// A transaction is taken in the idle state; each stored slot examined needs a
// read issue, then a compare, as the single slot memory has a registered read
// port; each result is handed to the output register. Throughput: one
// transaction at a time. Reset clears the fill counters and sets size_in_use
// to 32; the slot memory is not cleared and needs no pass.
`timescale 1ns / 1ps

module sparse_symmetric_matrix_lookup (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: size_in_use, written when cfg_wr_en is high.
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], position[36:32], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast    // last result of the command
);
    import sssl_pkg::*;

    // The size register. The effective size is clamped to the matrix dimension,
    // so a value of zero leaves every indexed command out of range.
    logic [5:0] size_in_use_reg;
    size_t      n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_in_use_reg <= 6'd32;
        end
        else if (cfg_wr_en)
        begin
            size_in_use_reg <= cfg_wr_data;
        end
    end

    assign n_eff = (N_W'(size_in_use_reg) > size_t'(SIZE)) ? size_t'(SIZE)
                                                          : N_W'(size_in_use_reg);

    // The sequencer reads, modifies and writes back the slot store; only one
    // command is in flight, so no two accesses to one slot ever overlap.
    store_req_t req;
    slot_t      rd_slot;
    fill_t      fill;
    logic       res_valid;
    result_t    res;
    logic       out_free;

    sssl_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_slot (rd_slot),
        .fill    (fill)
    );

    sssl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_row    (s_tdata[4:0]),
        .in_col    (s_tdata[9:5]),
        .in_value  (s_tdata[41:10]),
        .n         (n_eff),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .req       (req),
        .rd_slot   (rd_slot),
        .fill      (fill)
    );

    // Output register. It frees the sequencer as soon as a result has been
    // handed over, so the next command can be taken while that result waits.
    logic    m_valid_reg;
    result_t m_res_reg;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.position, m_res_reg.value};
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

endmodule

>>> hw/rtl/sssl_checker.sv
// Port-level checker for the sparse matrix lookup, bound to the top level.
`timescale 1ns / 1ps

module sssl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import sssl_pkg::*;

    // A stalled result must hold its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Out-of-range replies are a single, empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_RANGE) |-> m_tlast && (m_tdata == '0))
        else $error("out-of-range result malformed");

    // A row-full reply to a load is a single, empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tlast && (m_tdata == '0))
        else $error("row-full result malformed");

    // Only one command is in flight: after a transaction the input is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

endmodule

bind sparse_symmetric_matrix_lookup sssl_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/tb_sparse_symmetric_matrix_lookup.sv
// Self-checking testbench for the sparse symmetric similarity matrix lookup.
`timescale 1ns / 1ps

module tb_sparse_symmetric_matrix_lookup;

    import sssl_pkg::*;

    localparam int CLK_PERIOD         = 10;
    localparam int RESET_CYCLES       = 8;
    localparam int MAX_RESULTS        = 32;
    localparam int REPORT_LIMIT       = 10;
    localparam int WATCHDOG_LIMIT     = 20000;
    localparam int IDLE_SETTLE_CYCLES = 8;
    localparam int END_SETTLE_CYCLES  = 64;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int HOT_ROWS           = 4;

    // Command codes above CMD_CLEAR are not decoded by the block.
    localparam logic [2:0] CMD_RESERVED_LAST = 3'd7;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;   // row[4:0], col[9:5], value[41:10], zero pad
    logic [2:0]  s_tuser     = '0;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;            // result_value[31:0], position[36:32], zero pad
    logic [1:0]  m_tuser;            // status[1:0]
    logic        m_tlast;

    sparse_symmetric_matrix_lookup dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the matrix store and the size register.
    idx_t        slot_col_model [SIZE][NEIGHBORS];
    val_t        slot_val_model [SIZE][NEIGHBORS];
    int unsigned fill_model [SIZE];
    logic [5:0]  size_in_use_model;

    result_t     pending_results [$];
    result_t     oldest_result;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_cycles    = 0;
    int unsigned quiet_cycles   = 0;

    // ---------------------------------------------------------------- prediction

    function automatic int unsigned active_size();
        int unsigned n;
        n = size_in_use_model;
        if (n > SIZE) n = SIZE;
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        return n;
    endfunction

    // Slot of column c within row r, or -1 when the row does not hold it.
    function automatic int slot_of(int unsigned r, int unsigned c);
        int unsigned f;
        f = fill_model[r];
        if (f > NEIGHBORS) f = NEIGHBORS;
        for (int unsigned i = 0; i < f; i++)
            if (slot_col_model[r][i] == c) return i;
        return -1;
    endfunction

    // Entry (r,c), falling back to its mirror (c,r), else zero.
    function automatic val_t similarity_at(int unsigned r, int unsigned c);
        int s;
        s = slot_of(r, c);
        if (s >= 0) return slot_val_model[r][s];
        s = slot_of(c, r);
        if (s >= 0) return slot_val_model[c][s];
        return '0;
    endfunction

    function automatic void expect_result(val_t v, idx_t pos, logic [1:0] st, logic is_last);
        pending_results.push_back(result_t'{value: v, position: pos, status: st,
                                            last: is_last});
    endfunction

    function automatic void predict_results(logic [2:0] op, idx_t r, idx_t c, val_t v);
        int unsigned n;
        int          s;
        n = active_size();
        case (op)
            CMD_LOAD: begin
                if (r >= n || c >= n) begin
                    expect_result('0, '0, ST_RANGE, 1'b1);
                end else begin
                    s = slot_of(r, c);
                    if (s >= 0) begin
                        slot_val_model[r][s] = v;
                        expect_result('0, '0, ST_OK, 1'b1);
                    end else if (fill_model[r] >= NEIGHBORS) begin
                        expect_result('0, '0, ST_FULL, 1'b1);
                    end else begin
                        slot_col_model[r][fill_model[r]] = c;
                        slot_val_model[r][fill_model[r]] = v;
                        fill_model[r]++;
                        expect_result('0, '0, ST_OK, 1'b1);
                    end
                end
            end
            CMD_GET_VALUE: begin
                if (r >= n || c >= n)
                    expect_result('0, '0, ST_RANGE, 1'b1);
                else
                    expect_result(similarity_at(r, c), '0, ST_OK, 1'b1);
            end
            CMD_GET_ROW: begin
                if (r >= n) begin
                    expect_result('0, '0, ST_RANGE, 1'b1);
                end else begin
                    // A row query sees only what the row itself stores.
                    for (int unsigned i = 0; i < n; i++) begin
                        s = slot_of(r, i);
                        expect_result(s >= 0 ? slot_val_model[r][s] : '0, idx_t'(i), ST_OK,
                                      i + 1 == n);
                    end
                end
            end
            CMD_GET_COL: begin
                if (c >= n) begin
                    expect_result('0, '0, ST_RANGE, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < n; i++)
                        expect_result(similarity_at(i, c), idx_t'(i), ST_OK, i + 1 == n);
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < SIZE; i++) fill_model[i] = 0;
                expect_result('0, '0, ST_OK, 1'b1);
            end
            default: expect_result('0, '0, ST_OK, 1'b1);
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    // The receiver either serves a long hold-off or idles at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cycles != 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: ",
                             "value %h position %0d status %0d last %0b",
                             results_seen, m_tdata[31:0], m_tdata[36:32], m_tuser, m_tlast);
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_tdata[31:0] !== oldest_result.value
                        || m_tdata[36:32] !== oldest_result.position
                        || m_tuser !== oldest_result.status
                        || m_tlast !== oldest_result.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result %0d mismatch: ",
                                 "expected value %h position %0d status %0d last %0b, ",
                                 "got value %h position %0d status %0d last %0b",
                                 results_seen, oldest_result.value, oldest_result.position,
                                 oldest_result.status, oldest_result.last, m_tdata[31:0],
                                 m_tdata[36:32], m_tuser, m_tlast);
                end
            end
        end
    end

    // Ends the run when neither side moves a transaction for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sparse_symmetric_matrix_lookup failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- command side

    // Offers one command and returns in the time step of its handshake, leaving
    // s_tvalid high so that a following command can go out back to back.
    task automatic send_command(logic [2:0] op, idx_t r, idx_t c, val_t v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, v, c, r};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_results(op, r, c, v);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (IDLE_SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size_in_use(logic [5:0] new_size);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= new_size;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_in_use_model = new_size;
    endtask

    function automatic idx_t pick_index(int unsigned n);
        if (n == 0 || $urandom_range(0, 9) != 0) return idx_t'($urandom_range(0, n - 1));
        if (n < MAX_RESULTS) return idx_t'($urandom_range(n, MAX_RESULTS - 1));
        return idx_t'($urandom_range(0, MAX_RESULTS - 1));
    endfunction

    function automatic val_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return val_t'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_contents();
        send_command(CMD_GET_VALUE, 5'd0, 5'd0, '0);
        send_command(CMD_GET_ROW, 5'd31, 5'd0, '0);
    endtask

    task automatic test_load_and_symmetry();
        send_command(CMD_LOAD, 5'd0, 5'd31, 32'h7FFF_FFFF);
        send_command(CMD_LOAD, 5'd31, 5'd0, 32'h8000_0000);
        send_command(CMD_GET_VALUE, 5'd0, 5'd31, '0);
        send_command(CMD_LOAD, 5'd5, 5'd9, 32'h0001_8000);
        // Only (5,9) is stored, so (9,5) must come from its mirror.
        send_command(CMD_GET_VALUE, 5'd9, 5'd5, '0);
        send_command(CMD_LOAD, 5'd5, 5'd9, 32'hFFFE_4000);
        send_command(CMD_GET_ROW, 5'd9, 5'd0, '0);
        send_command(CMD_GET_COL, 5'd0, 5'd9, '0);
    endtask

    task automatic test_row_full();
        for (int i = 0; i < NEIGHBORS; i++)
            send_command(CMD_LOAD, 5'd3, idx_t'(i + 10), val_t'($urandom));
        // A new column is refused, an existing one may still be rewritten.
        send_command(CMD_LOAD, 5'd3, 5'd2, 32'h0000_0100);
        send_command(CMD_LOAD, 5'd3, 5'd10, 32'h1234_5678);
        send_command(CMD_GET_ROW, 5'd3, 5'd0, '0);
    endtask

    task automatic test_size_limits();
        write_size_in_use(6'd16);
        send_command(CMD_LOAD, 5'd16, 5'd0, 32'h0000_0001);
        send_command(CMD_GET_VALUE, 5'd0, 5'd16, '0);
        send_command(CMD_GET_ROW, 5'd20, 5'd0, '0);
        send_command(CMD_GET_COL, 5'd0, 5'd16, '0);
        send_command(CMD_GET_ROW, 5'd0, 5'd0, '0);
        write_size_in_use(6'd0);
        send_command(CMD_GET_VALUE, 5'd0, 5'd0, '0);
        write_size_in_use(6'd1);
        send_command(CMD_GET_COL, 5'd0, 5'd0, '0);
        // Growing back makes the hidden entries visible again.
        write_size_in_use(6'd63);
        send_command(CMD_GET_VALUE, 5'd31, 5'd0, '0);
        write_size_in_use(6'd32);
    endtask

    task automatic test_clear_and_unknown();
        send_command(CMD_CLEAR, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_command(CMD_GET_VALUE, 5'd5, 5'd9, '0);
        for (logic [3:0] op = {1'b0, CMD_CLEAR} + 4'd1; op <= {1'b0, CMD_RESERVED_LAST};
             op++)
            send_command(op[2:0], 5'd31, 5'd31, 32'hFFFF_FFFF);
    endtask

    // The receiver stops for a long stretch while queries keep coming, so the
    // output path backs up and the command input has to stall.
    task automatic test_output_backpressure();
        wait_until_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = HOLD_OFF_CYCLES;
        for (int i = 0; i < 4; i++) begin
            send_command(CMD_LOAD, idx_t'(i), idx_t'(i + 20), val_t'($urandom));
            send_command(CMD_GET_ROW, idx_t'(i), 5'd0, '0);
        end
        wait_until_idle();
    endtask

    task automatic test_random_traffic(int unsigned items, int unsigned send_pct,
                                       int unsigned recv_pct, logic [5:0] new_size);
        logic [2:0]  op;
        idx_t        r;
        idx_t        c;
        val_t        v;
        int unsigned n;
        int unsigned pick;
        write_size_in_use(new_size);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        n = active_size();
        repeat (items) begin
            pick = $urandom_range(0, 99);
            r = pick_index(n);
            c = pick_index(n);
            v = pick_value();
            if (pick < 8) begin
                // Noise: any code, any index.
                op = 3'($urandom_range(0, 7));
                r  = idx_t'($urandom_range(0, MAX_RESULTS - 1));
                c  = idx_t'($urandom_range(0, MAX_RESULTS - 1));
            end else if (pick < 52) begin
                op = CMD_LOAD;
                // Half the loads go to a few rows so that they fill up.
                if ($urandom_range(0, 1) != 0) r = idx_t'($urandom_range(0, HOT_ROWS - 1) % n);
            end else if (pick < 76) begin
                op = CMD_GET_VALUE;
            end else if (pick < 87) begin
                op = CMD_GET_ROW;
            end else if (pick < 98) begin
                op = CMD_GET_COL;
            end else begin
                op = CMD_CLEAR;
            end
            send_command(op, r, c, v);
        end
    endtask

    initial begin
        size_in_use_model = 6'd32;
        for (int i = 0; i < SIZE; i++) fill_model[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 84;
        test_reset_contents();
        test_load_and_symmetry();
        test_row_full();
        test_size_limits();
        test_clear_and_unknown();
        test_output_backpressure();

        test_random_traffic(53, 32, 84, 6'd32);
        test_random_traffic(53, 84, 32, 6'($urandom_range(1, 31)));
        test_random_traffic(53, 0, 0, 6'($urandom_range(8, 32)));

        wait_until_idle();
        repeat (END_SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_sparse_symmetric_matrix_lookup passed");
        else
            $display("tb_sparse_symmetric_matrix_lookup failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sssl_pkg.sv
hw/rtl/sssl_slot_store.sv
hw/rtl/sssl_seq.sv
hw/rtl/sparse_symmetric_matrix_lookup.sv
hw/rtl/sssl_checker.sv
tb/tb_sparse_symmetric_matrix_lookup.sv
